[design/rnf_pkg.sv]
`timescale 1ns / 1ps

package rnf_pkg;

    localparam int NAL_LEN_W = 20;
    localparam int CHUNK_W   = 11;
    localparam int SEQ_W     = 16;

    // Configuration register indexes.
    localparam logic [0:0] CFG_CODEC_SELECT = 1'b0;
    localparam logic [0:0] CFG_CHUNK_SIZE   = 1'b1;

    localparam logic [CHUNK_W-1:0] CHUNK_MIN   = 11'd16;
    localparam logic [CHUNK_W-1:0] CHUNK_RESET = 11'd1400;

    // FU prefix construction.
    localparam logic [7:0] H264_NRI_MASK   = 8'h60;
    localparam logic [7:0] H264_FU_A_TYPE  = 8'd28;
    localparam logic [7:0] H264_TYPE_MASK  = 8'h1F;
    localparam logic [7:0] H265_KEEP_MASK  = 8'h81;
    localparam logic [7:0] H265_FU_TYPE    = 8'd98;   // type 49 shifted into bits 6:1
    localparam logic [7:0] H265_TYPE_MASK  = 8'h7E;
    localparam logic [7:0] FU_START        = 8'h80;
    localparam logic [7:0] FU_END          = 8'h40;

    typedef struct packed {
        logic [7:0]           nal_byte;
        logic                 first_of_nal;
        logic [NAL_LEN_W-1:0] nal_length;
    } rnf_in_t;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic             packet_start;
        logic             packet_end;
        logic [SEQ_W-1:0] sequence_number;
        logic             last_of_run;
    } rnf_out_t;

    // All results caused by one input item; the payload byte is at last_idx.
    typedef struct packed {
        logic [3:0][7:0]  data;
        logic [1:0]       last_idx;
        logic             start;
        logic             stop;
        logic [SEQ_W-1:0] seq;
    } rnf_bundle_t;

endpackage

[design/rnf_core.sv]
`timescale 1ns / 1ps

module rnf_core #(
    parameter int LEN_W = 20
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    input  rnf_pkg::rnf_in_t           item,
    input  logic                       codec_select,
    input  logic [rnf_pkg::CHUNK_W-1:0] chunk_size,
    input  logic                       bundle_free,
    output logic                       advance,
    output logic                       load,
    output rnf_pkg::rnf_bundle_t       bundle
);
    import rnf_pkg::*;

    logic [SEQ_W-1:0]   seq_reg, seq_next;
    logic [LEN_W-1:0]   left_reg, left_next;
    logic [CHUNK_W-1:0] fill_reg, fill_next;
    logic               frag_reg, frag_next;
    logic [15:0]        held_reg, held_next;
    logic [1:0]         hidx_reg, hidx_next;
    logic               fc_reg, fc_next;

    logic [CHUNK_W-1:0] csz;
    logic [LEN_W-1:0]   csz_ext;
    logic [LEN_W-1:0]   len_in;
    logic [1:0]         hdr_len;
    logic [7:0]         h0;
    logic [7:0]         h1;
    logic [7:0]         flags;
    logic               has_result;
    logic               stop;
    logic               full_hit;

    always_comb
    begin
        csz     = (chunk_size < CHUNK_MIN) ? CHUNK_MIN : chunk_size;
        csz_ext = LEN_W'(csz);
        len_in  = item.nal_length[LEN_W-1:0];
        if (len_in == '0)
        begin
            len_in = LEN_W'(1);
        end
        hdr_len = codec_select ? 2'd2 : 2'd1;

        seq_next  = seq_reg;
        left_next = left_reg;
        fill_next = fill_reg;
        frag_next = frag_reg;
        held_next = held_reg;
        hidx_next = hidx_reg;
        fc_next   = fc_reg;

        // A first byte restarts the NAL unit before anything else is decided.
        if (item.first_of_nal)
        begin
            left_next = len_in;
            frag_next = len_in > csz_ext;
            hidx_next = 2'd0;
            fill_next = '0;
            fc_next   = 1'b1;
            held_next = 16'h0000;
        end

        h0         = held_next[15:8];
        h1         = held_next[7:0];
        flags      = 8'h00;
        stop       = 1'b0;
        full_hit   = 1'b0;
        has_result = 1'b0;
        bundle     = '0;
        bundle.seq = seq_reg;

        if (left_next != '0)
        begin
            if (!frag_next)
            begin
                has_result       = 1'b1;
                bundle.data[0]   = item.nal_byte;
                bundle.last_idx  = 2'd0;
                bundle.start     = item.first_of_nal;
                bundle.stop      = (left_next == LEN_W'(1));
                if (bundle.stop)
                begin
                    seq_next = seq_reg + 16'd1;
                end
            end
            else if (hidx_next < hdr_len)
            begin
                if (hidx_next == 2'd0)
                begin
                    held_next = {item.nal_byte, 8'h00};
                end
                else
                begin
                    held_next = {held_next[15:8], item.nal_byte};
                end
                hidx_next = hidx_next + 2'd1;
            end
            else
            begin
                has_result = 1'b1;
                full_hit   = ({1'b0, fill_next} + 12'd1) >= {1'b0, csz};
                if (fc_next)
                begin
                    stop = full_hit || (left_next == LEN_W'(1)) ||
                           ((left_next == LEN_W'(2)) &&
                            (({1'b0, fill_next} + 12'd2) <= {1'b0, csz}));
                end
                else
                begin
                    stop = full_hit || (left_next == LEN_W'(1));
                end

                if (fill_next == '0)
                begin
                    if (fc_next)
                    begin
                        flags = FU_START;
                    end
                    else if (left_next <= csz_ext)
                    begin
                        flags = FU_END;
                    end
                    bundle.start = 1'b1;
                    if (codec_select)
                    begin
                        bundle.data[0]  = (h0 & H265_KEEP_MASK) | H265_FU_TYPE;
                        bundle.data[1]  = h1;
                        bundle.data[2]  = ((h0 & H265_TYPE_MASK) >> 1) | flags;
                        bundle.data[3]  = item.nal_byte;
                        bundle.last_idx = 2'd3;
                    end
                    else
                    begin
                        bundle.data[0]  = (h0 & H264_NRI_MASK) | H264_FU_A_TYPE;
                        bundle.data[1]  = (h0 & H264_TYPE_MASK) | flags;
                        bundle.data[2]  = item.nal_byte;
                        bundle.last_idx = 2'd2;
                    end
                end
                else
                begin
                    bundle.data[0]  = item.nal_byte;
                    bundle.last_idx = 2'd0;
                end
                bundle.stop = stop;

                if (stop)
                begin
                    fill_next = '0;
                    fc_next   = 1'b0;
                    seq_next  = seq_reg + 16'd1;
                end
                else
                begin
                    fill_next = fill_next + 11'd1;
                end
            end

            left_next = left_next - LEN_W'(1);
            if (left_next == '0)
            begin
                frag_next = 1'b0;
                fc_next   = 1'b1;
                hidx_next = 2'd0;
                fill_next = '0;
            end
        end
    end

    assign advance = item_valid && (!has_result || bundle_free);
    assign load    = advance && has_result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg  <= '0;
            left_reg <= '0;
            fill_reg <= '0;
            frag_reg <= 1'b0;
            held_reg <= 16'h0000;
            hidx_reg <= 2'd0;
            fc_reg   <= 1'b1;
        end
        else if (advance)
        begin
            seq_reg  <= seq_next;
            left_reg <= left_next;
            fill_reg <= fill_next;
            frag_reg <= frag_next;
            held_reg <= held_next;
            hidx_reg <= hidx_next;
            fc_reg   <= fc_next;
        end
    end

    // The sequence number only ever steps by one.
    assert property (@(posedge clk) disable iff (!rst_n)
        ##1 (seq_reg == $past(seq_reg)) || (seq_reg == $past(seq_reg) + 16'd1))
        else $error("sequence number jumped");

    // A result bundle is never pushed onto one still being drained.
    assert property (@(posedge clk) disable iff (!rst_n)
        load |-> bundle_free)
        else $error("bundle overwritten");

    // Header bytes are only held while a fragmented NAL unit is open.
    assert property (@(posedge clk) disable iff (!rst_n)
        (hidx_reg != 2'd0) |-> frag_reg)
        else $error("header held outside fragmentation");

endmodule

[design/rnf_serializer.sv]
`timescale 1ns / 1ps

module rnf_serializer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  rnf_pkg::rnf_bundle_t bundle,
    output logic                 bundle_free,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rnf_pkg::rnf_out_t    out_item
);
    import rnf_pkg::*;

    rnf_bundle_t bnd_reg;
    logic        valid_reg;
    logic [1:0]  idx_reg;
    logic        take;
    logic        is_last;
    logic        done;

    assign take        = valid_reg && out_ready;
    assign is_last     = (idx_reg == bnd_reg.last_idx);
    assign done        = take && is_last;
    assign bundle_free = !valid_reg || done;

    assign out_valid                = valid_reg;
    assign out_item.out_byte        = bnd_reg.data[idx_reg];
    assign out_item.packet_start    = bnd_reg.start && (idx_reg == 2'd0);
    assign out_item.packet_end      = bnd_reg.stop && is_last;
    assign out_item.sequence_number = bnd_reg.seq;
    assign out_item.last_of_run     = is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= 2'd0;
        end
        else if (done)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else if (take)
        begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bnd_reg <= bundle;
        end
    end

endmodule

[design/rtp_nal_fragmenter_top.sv]
`timescale 1ns / 1ps

// RTP packetizer for H.264 / H.265 NAL units, one NAL byte per input item.
// Input channel in_valid/in_ready carries nal_byte, first_of_nal and, with
// the first byte, nal_length. Output channel out_valid/out_ready carries one
// payload byte per item with packet start/end marks and the 16-bit sequence
// number of its packet; last_of_run flags the final result of an input byte.
// NAL units up to chunk_size bytes (raised to 16 if smaller) pass as one packet; longer ones
// are cut into FU packets, each opened by a 2-byte (H.264) or 3-byte (H.265)
// prefix. Header bytes of a fragmented NAL produce no output.
// An accepted byte waits in the input register, and its results in the result
// register, before the first of them is offered on out_valid.
// Throughput: one input byte per cycle while each byte yields one result and
// the receiver takes every result; a byte that opens a fragment yields 3
// (H.264) or 4 (H.265) results, sent one by one on the single output byte lane.
// The input register and the result register decouple the two sides, so a
// new byte is taken while a finished result still waits. When the receiver
// stalls, results hold and the input stops once both registers are full.
// Reset clears the sequence number and all NAL state; codec_select returns
// to H.264 and chunk_size to 1400. Configure only while the block is idle.

module rtp_nal_fragmenter_top #(
    parameter int LENGTH_BITS = 20
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [0:0]                  cfg_index,
    input  logic [rnf_pkg::CHUNK_W-1:0] cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  rnf_pkg::rnf_in_t            in_item,
    output logic                        out_valid,
    input  logic                        out_ready,
    output rnf_pkg::rnf_out_t           out_item
);
    import rnf_pkg::*;

    localparam int LEN_W = (LENGTH_BITS < NAL_LEN_W) ? LENGTH_BITS : NAL_LEN_W;

    logic               codec_reg;
    logic [CHUNK_W-1:0] chunk_reg;
    logic               item_valid_reg;
    rnf_in_t            item_reg;
    logic               advance;
    logic               load;
    logic               bundle_free;
    rnf_bundle_t        bundle;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            codec_reg <= 1'b0;
            chunk_reg <= CHUNK_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CODEC_SELECT: codec_reg <= cfg_data[0];
                CFG_CHUNK_SIZE:   chunk_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign in_ready = !item_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            item_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    rnf_core #(
        .LEN_W(LEN_W)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid_reg),
        .item        (item_reg),
        .codec_select(codec_reg),
        .chunk_size  (chunk_reg),
        .bundle_free (bundle_free),
        .advance     (advance),
        .load        (load),
        .bundle      (bundle)
    );

    rnf_serializer u_serializer (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .bundle     (bundle),
        .bundle_free(bundle_free),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_item   (out_item)
    );

    // A held input byte is not lost while the result side is busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg && !advance |=> item_valid_reg)
        else $error("held input byte dropped");

    // A packet can only end on the final result of an input byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.packet_end |-> out_item.last_of_run)
        else $error("packet end before last result");

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    import rnf_pkg::*;

    localparam int NUM_ROWS      = 17;
    localparam int SETTLE_CYCLES = 6;
    localparam int STALL_LIMIT   = 3000;
    localparam int PRESSURE_HOLD = 300;
    localparam int MAX_PRINTS    = 50;

    typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_e;

    typedef struct packed {
        row_kind_e            kind;
        logic [7:0]           val;
        logic                 first;
        logic [NAL_LEN_W-1:0] len;
        int                   count;
        logic                 typed;
        rnf_out_t             res;
        logic [0:0]           reg_idx;
        logic [CHUNK_W-1:0]   reg_val;
    } dir_row_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [0:0]         cfg_index = '0;
    logic [CHUNK_W-1:0] cfg_data  = '0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    rnf_in_t            in_item   = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    rnf_out_t           out_item;

    // Mirror of the configuration registers.
    logic               cfg_codec = 1'b0;
    logic [CHUNK_W-1:0] cfg_chunk = CHUNK_RESET;

    // Packetizer state as the block should hold it.
    logic [SEQ_W-1:0]     exp_seq       = '0;
    logic [NAL_LEN_W-1:0] nal_remaining = '0;
    logic [CHUNK_W-1:0]   frag_fill     = '0;
    logic                 in_fu         = 1'b0;
    logic [15:0]          hdr_hold      = '0;
    logic [1:0]           hdr_count     = '0;
    logic                 opening_chunk = 1'b1;

    rnf_out_t pkt_buf [4];
    int       pkt_count;
    rnf_out_t pending_payload [$];
    rnf_out_t want_item;

    int error_count    = 0;
    int stall_cycles   = 0;
    int send_idle      = 30;
    int recv_idle      = 78;
    bit pressure_req   = 1'b0;
    bit pressure_taken = 1'b0;
    int hold_left      = 0;

    rnf_in_t stim_item;

    dir_row_t dir_rows [NUM_ROWS] = '{
        '{ROW_ITEM, 8'hAA, 1'b1, 20'd2, 1, 1'b1, '{8'hAA, 1'b1, 1'b0, 16'd0, 1'b1}, '0, '0},
        '{ROW_ITEM, 8'hBB, 1'b0, 20'd0, 1, 1'b1, '{8'hBB, 1'b0, 1'b1, 16'd0, 1'b1}, '0, '0},
        '{ROW_ITEM, 8'h55, 1'b0, 20'd0, 1, 1'b0, '0, '0, '0},
        '{ROW_ITEM, 8'hFF, 1'b1, 20'd0, 1, 1'b1, '{8'hFF, 1'b1, 1'b1, 16'd1, 1'b1}, '0, '0},
        '{ROW_ITEM, 8'h00, 1'b1, 20'd1, 1, 1'b1, '{8'h00, 1'b1, 1'b1, 16'd2, 1'b1}, '0, '0},
        '{ROW_ITEM, 8'h7C, 1'b1, 20'hFFFFF, 4, 1'b0, '0, '0, '0},
        '{ROW_ITEM, 8'h11, 1'b1, 20'd3, 3, 1'b0, '0, '0, '0},
        '{ROW_CFG, 8'h00, 1'b0, 20'd0, 0, 1'b0, '0, CFG_CHUNK_SIZE, 11'd3},
        '{ROW_ITEM, 8'h65, 1'b1, 20'd17, 17, 1'b0, '0, '0, '0},
        '{ROW_CFG, 8'h00, 1'b0, 20'd0, 0, 1'b0, '0, CFG_CODEC_SELECT, 11'd1},
        '{ROW_ITEM, 8'h40, 1'b1, 20'd16, 16, 1'b0, '0, '0, '0},
        '{ROW_ITEM, 8'h26, 1'b1, 20'd40, 40, 1'b0, '0, '0, '0},
        '{ROW_CFG, 8'h00, 1'b0, 20'd0, 0, 1'b0, '0, CFG_CHUNK_SIZE, 11'd2047},
        '{ROW_ITEM, 8'hFF, 1'b1, 20'hFFFFF, 4, 1'b0, '0, '0, '0},
        '{ROW_ITEM, 8'h01, 1'b1, 20'd2, 2, 1'b0, '0, '0, '0},
        '{ROW_CFG, 8'h00, 1'b0, 20'd0, 0, 1'b0, '0, CFG_CODEC_SELECT, 11'd0},
        '{ROW_CFG, 8'h00, 1'b0, 20'd0, 0, 1'b0, '0, CFG_CHUNK_SIZE, CHUNK_RESET}
    };

    rtp_nal_fragmenter_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    always #5 clk = ~clk;

    function automatic void emit_byte(input logic [7:0] b, input logic s, input logic e);
        pkt_buf[pkt_count] = '{out_byte: b, packet_start: s, packet_end: e,
                               sequence_number: exp_seq, last_of_run: 1'b0};
        pkt_count++;
    endfunction

    // Advances the packetizer state by one NAL byte and leaves the results it
    // causes in pkt_buf; returns how many there are.
    function automatic int packetize_byte(input rnf_in_t item);
        logic [NAL_LEN_W-1:0] len;
        logic [CHUNK_W-1:0]   csz;
        logic [1:0]           hlen;
        logic [7:0]           h0;
        logic [7:0]           h1;
        logic [7:0]           flags;
        logic                 fin;
        len       = item.nal_length;
        csz       = (cfg_chunk < CHUNK_MIN) ? CHUNK_MIN : cfg_chunk;
        hlen      = cfg_codec ? 2'd2 : 2'd1;
        pkt_count = 0;
        if (item.first_of_nal)
        begin
            if (len == 0)
                len = NAL_LEN_W'(1);
            nal_remaining = len;
            in_fu         = len > csz;
            hdr_count     = '0;
            frag_fill     = '0;
            opening_chunk = 1'b1;
            hdr_hold      = '0;
        end
        if (nal_remaining == 0)
            return 0;
        if (!in_fu)
        begin
            fin = nal_remaining == 1;
            emit_byte(item.nal_byte, item.first_of_nal, fin);
            if (fin)
                exp_seq++;
        end
        else if (hdr_count < hlen)
        begin
            if (hdr_count == 0)
                hdr_hold = {item.nal_byte, 8'h00};
            else
                hdr_hold[7:0] = item.nal_byte;
            hdr_count++;
        end
        else
        begin
            h0  = hdr_hold[15:8];
            h1  = hdr_hold[7:0];
            fin = (32'(frag_fill) + 1 >= 32'(csz)) || nal_remaining == 1;
            // The opening fragment stops one byte short so that S and E never meet.
            if (opening_chunk && nal_remaining == 2 && 32'(nal_remaining) + 32'(frag_fill) <= 32'(csz))
                fin = 1'b1;
            if (frag_fill == 0)
            begin
                flags = 8'h00;
                if (opening_chunk)
                    flags = FU_START;
                else if (nal_remaining <= csz)
                    flags = FU_END;
                if (cfg_codec)
                begin
                    emit_byte((h0 & H265_KEEP_MASK) | H265_FU_TYPE, 1'b1, 1'b0);
                    emit_byte(h1, 1'b0, 1'b0);
                    emit_byte(((h0 & H265_TYPE_MASK) >> 1) | flags, 1'b0, 1'b0);
                end
                else
                begin
                    emit_byte((h0 & H264_NRI_MASK) | H264_FU_A_TYPE, 1'b1, 1'b0);
                    emit_byte((h0 & H264_TYPE_MASK) | flags, 1'b0, 1'b0);
                end
            end
            emit_byte(item.nal_byte, 1'b0, fin);
            if (fin)
            begin
                frag_fill     = '0;
                opening_chunk = 1'b0;
                exp_seq++;
            end
            else
                frag_fill++;
        end
        nal_remaining--;
        if (nal_remaining == 0)
        begin
            in_fu         = 1'b0;
            opening_chunk = 1'b1;
            hdr_count     = '0;
            frag_fill     = '0;
        end
        if (pkt_count > 0)
            pkt_buf[pkt_count-1].last_of_run = 1'b1;
        return pkt_count;
    endfunction

    task automatic report_error(input string msg);
        if (error_count < MAX_PRINTS)
            $display("ERROR at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_error($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    task automatic send_item(input rnf_in_t item, input logic typed, input rnf_out_t typed_res);
        int n;
        @(negedge clk);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        n = packetize_byte(item);
        if (typed)
            pending_payload.push_back(typed_res);
        else
            for (int i = 0; i < n; i++)
                pending_payload.push_back(pkt_buf[i]);
    endtask

    // Writes only once every result is out and any header byte has settled.
    task automatic write_reg(input logic [0:0] idx, input logic [CHUNK_W-1:0] val);
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_payload.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == CFG_CODEC_SELECT)
            cfg_codec = val[0];
        else
            cfg_chunk = val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Mostly whole NAL units, with truncated ones and stray bytes mixed in.
    task automatic run_random(input int n_items);
        int          sent;
        int          kind;
        int          nbytes;
        int          csz;
        logic [19:0] len;
        sent = 0;
        while (sent < n_items)
        begin
            kind = $urandom_range(99);
            csz  = (cfg_chunk < CHUNK_MIN) ? CHUNK_MIN : cfg_chunk;
            if (kind < 6 && nal_remaining == 0)
            begin
                stim_item.nal_byte     = 8'($urandom);
                stim_item.first_of_nal = 1'b0;
                stim_item.nal_length   = 20'($urandom);
                send_item(stim_item, 1'b0, '0);
                continue;
            end
            if (kind < 16)
            begin
                len    = 20'($urandom);
                nbytes = $urandom_range(5, 1);
            end
            else
            begin
                if (csz <= 64)
                    len = 20'($urandom_range(3 * csz + 3, 1));
                else
                    len = 20'($urandom_range(80, 1));
                if ($urandom_range(19) == 0)
                    len = '0;
                nbytes = (len == 0) ? 1 : int'(len);
            end
            if (nbytes > n_items - sent)
                nbytes = n_items - sent;
            for (int i = 0; i < nbytes; i++)
            begin
                stim_item.nal_byte     = 8'($urandom);
                stim_item.first_of_nal = (i == 0);
                stim_item.nal_length   = (i == 0) ? len : 20'($urandom);
                send_item(stim_item, 1'b0, '0);
                sent++;
            end
        end
    endtask

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < NUM_ROWS; r++)
        begin
            if (dir_rows[r].kind == ROW_CFG)
                write_reg(dir_rows[r].reg_idx, dir_rows[r].reg_val);
            else
                for (int i = 0; i < dir_rows[r].count; i++)
                begin
                    stim_item.nal_byte     = dir_rows[r].val + 8'(i);
                    stim_item.first_of_nal = dir_rows[r].first && (i == 0);
                    stim_item.nal_length   = (i == 0) ? dir_rows[r].len : '0;
                    send_item(stim_item, dir_rows[r].typed, dir_rows[r].res);
                end
        end

        for (int mode = 0; mode < 3; mode++)
        begin
            case (mode)
                0:
                begin
                    send_idle = 30;
                    recv_idle = 78;
                    write_reg(CFG_CHUNK_SIZE, CHUNK_MIN);
                    run_random(36);
                    write_reg(CFG_CODEC_SELECT, 11'd1);
                    write_reg(CFG_CHUNK_SIZE, 11'($urandom_range(48, 17)));
                    run_random(36);
                end
                1:
                begin
                    send_idle = 78;
                    recv_idle = 30;
                    write_reg(CFG_CHUNK_SIZE, CHUNK_MIN);
                    run_random(36);
                    write_reg(CFG_CODEC_SELECT, 11'd0);
                    write_reg(CFG_CHUNK_SIZE, 11'($urandom_range(15, 0)));
                    run_random(36);
                end
                default:
                begin
                    send_idle = 0;
                    recv_idle = 0;
                    write_reg(CFG_CODEC_SELECT, 11'd1);
                    write_reg(CFG_CHUNK_SIZE, 11'd2047);
                    pressure_req = 1'b1;
                    run_random(36);
                    write_reg(CFG_CODEC_SELECT, 11'd0);
                    write_reg(CFG_CHUNK_SIZE, 11'($urandom_range(40, 16)));
                    run_random(36);
                end
            endcase
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_payload.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Receiver: random back-pressure, plus one long hold once the pressure
    // phase begins so that the block fills and stalls its input.
    always @(negedge clk)
    begin
        if (pressure_req && !pressure_taken)
        begin
            pressure_taken = 1'b1;
            hold_left      = PRESSURE_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_payload.size() == 0)
                report_error($sformatf("unexpected item: byte %02h seq %0d",
                                       out_item.out_byte, out_item.sequence_number));
            else
            begin
                want_item = pending_payload.pop_front();
                check_field("out_byte", 16'(out_item.out_byte), 16'(want_item.out_byte));
                check_field("packet_start", 16'(out_item.packet_start),
                            16'(want_item.packet_start));
                check_field("packet_end", 16'(out_item.packet_end), 16'(want_item.packet_end));
                check_field("sequence_number", out_item.sequence_number,
                            want_item.sequence_number);
                check_field("last_of_run", 16'(out_item.last_of_run),
                            16'(want_item.last_of_run));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

endmodule
